// ===== src/ggcd_pkg.sv =====
// Shared constants, types and register codes for the grid gradient block.
package ggcd_pkg;

   // Grid and sample geometry
   localparam int MAX_ROWS    = 32;
   localparam int SAMPLE_BITS = 16;
   localparam int ROW_W       = $clog2(MAX_ROWS);
   localparam int COL_W       = 16;
   localparam int ROWS_CFG_W  = 6;
   localparam int INV_W       = 16;
   localparam int GRAD_W      = 25;

   // Column store: three column slots, each 2**ROW_W rows
   localparam int SLOT_W      = 2;
   localparam int STORE_AW    = SLOT_W + ROW_W;
   localparam int STORE_DEPTH = 3 * (2 ** ROW_W);

   // Datapath widths
   localparam int DIFF_W      = SAMPLE_BITS + 1;
   localparam int PROD_W      = DIFF_W + INV_W + 1;

   // Result queue
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

   // Configuration port
   localparam int CSR_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_STEP_ROW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_STEP_COL = 2'd3;
   localparam logic [INV_W-1:0]     INV_RESET        = 16'd256;

   // Effective configuration (dimensions held as size minus one)
   typedef struct packed {
      logic [ROW_W-1:0] rows_m1;
      logic [COL_W-1:0] cols_m1;
      logic [INV_W-1:0] inv_row;
      logic [INV_W-1:0] inv_col;
   } ggcd_cfg_type;

   // Store accesses for one cycle
   typedef struct packed {
      logic                   wr_en;
      logic [STORE_AW-1:0]    wr_addr;
      logic [SAMPLE_BITS-1:0] wr_data;
      logic [STORE_AW-1:0]    row_addr_hi;
      logic [STORE_AW-1:0]    row_addr_lo;
      logic [STORE_AW-1:0]    col_addr_hi;
      logic [STORE_AW-1:0]    col_addr_lo;
   } ggcd_mem_type;

   // One grid point on its way through the arithmetic
   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row_index;
      logic [COL_W-1:0] col_index;
      logic             row_zero;
      logic             row_sh9;
      logic             col_zero;
      logic             col_sh9;
      logic             last_of_run;
      logic             frame_done;
   } ggcd_point_type;

   // Finished result
   typedef struct packed {
      logic [ROW_W-1:0]         row_index;
      logic [COL_W-1:0]         col_index;
      logic signed [GRAD_W-1:0] grad_row;
      logic signed [GRAD_W-1:0] grad_col;
      logic                     last_of_run;
      logic                     frame_done;
   } ggcd_rsp_type;

   typedef struct packed {
      logic         valid;
      ggcd_rsp_type data;
   } ggcd_push_type;

endpackage

// ===== src/ggcd_req_if.sv =====
// Sample channel: valid/ready handshake with one signed sample per beat.
interface ggcd_req_if import ggcd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== src/ggcd_rsp_if.sv =====
// Result channel: valid/ready handshake with one gradient point per beat.
interface ggcd_rsp_if import ggcd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [ROW_W-1:0]         row_index;
   logic [COL_W-1:0]         col_index;
   logic signed [GRAD_W-1:0] grad_row;
   logic signed [GRAD_W-1:0] grad_col;
   logic                     last_of_run;
   logic                     frame_done;

   modport source (output valid, output row_index, output col_index, output grad_row,
                   output grad_col, output last_of_run, output frame_done, input ready);
   modport sink   (input valid, input row_index, input col_index, input grad_row,
                   input grad_col, input last_of_run, input frame_done, output ready);
endinterface

// ===== src/ggcd_ram.sv =====
// Generic RAM: one write port, two registered read ports, read-first.
module ggcd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write and read in the same cycle; a read of the written entry returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== src/ggcd_seq.sv =====
// Sequencer: grid counters, store writes, and issue of released points to the store reads.
module ggcd_seq import ggcd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   ggcd_req_if.sink       req,
   input  ggcd_cfg_type   cfg,
   input  logic           rsp_pop,
   output ggcd_mem_type   mem,
   output ggcd_point_type point
);

   localparam int PEND_LEFT  = 0;
   localparam int PEND_ABOVE = 1;
   localparam int PEND_SELF  = 2;

   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      return (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
      return (s == 2'd0) ? 2'd2 : s - 2'd1;
   endfunction

   // Grid position of the next sample
   logic [ROW_W-1:0]  row_count_ff, row_count_in;
   logic [COL_W-1:0]  col_count_ff, col_count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // Held job: points still to issue for the last accepted sample
   logic [2:0]        pend_ff, pend_in;
   logic [ROW_W-1:0]  job_r_ff;
   logic [COL_W-1:0]  job_c_ff;
   logic [SLOT_W-1:0] job_s_ff;

   logic [FIFO_CW-1:0] outstanding_ff, outstanding_in;

   logic              restart, accept, last_row, last_col, issue, credit_ok;
   logic [ROW_W-1:0]  cur_r;
   logic [COL_W-1:0]  cur_c;
   logic [SLOT_W-1:0] cur_s;
   logic [2:0]        new_pend, rem;
   logic [ROW_W-1:0]  pr, row_hi, row_lo;
   logic [COL_W-1:0]  pc;
   logic [SLOT_W-1:0] sp, col_hi_s, col_lo_s;

   // Resolve the current position, restarting a frame when a counter is out of range
   always_comb begin
      restart  = (row_count_ff > cfg.rows_m1) || (col_count_ff > cfg.cols_m1);
      cur_r    = restart ? '0 : row_count_ff;
      cur_c    = restart ? '0 : col_count_ff;
      cur_s    = restart ? '0 : slot_ff;
      last_row = (cur_r == cfg.rows_m1);
      last_col = (cur_c == cfg.cols_m1);
      new_pend[PEND_LEFT]  = (cur_c != '0);
      new_pend[PEND_ABOVE] = last_col && (cur_r != '0);
      new_pend[PEND_SELF]  = last_col && last_row;
   end

   // Pick the oldest pending point of the held job
   always_comb begin
      if (pend_ff[PEND_LEFT]) begin
         pr  = job_r_ff;
         pc  = job_c_ff - 1'b1;
         sp  = slot_dec(job_s_ff);
         rem = pend_ff & 3'b110;
      end else if (pend_ff[PEND_ABOVE]) begin
         pr  = job_r_ff - 1'b1;
         pc  = job_c_ff;
         sp  = job_s_ff;
         rem = pend_ff & 3'b100;
      end else begin
         pr  = job_r_ff;
         pc  = job_c_ff;
         sp  = job_s_ff;
         rem = 3'b000;
      end
   end

   // Issue when the result queue has room; take a sample once the job is about to empty
   always_comb begin
      credit_ok = (outstanding_ff != FIFO_CW'(FIFO_DEPTH));
      issue     = (pend_ff != 3'b000) && credit_ok;
      req.ready = (pend_ff == 3'b000) || (issue && (rem == 3'b000));
      accept    = req.valid && req.ready;
   end

   // Neighbor rows and columns, clamped at the grid edges
   always_comb begin
      row_hi   = (pr == cfg.rows_m1) ? pr : pr + 1'b1;
      row_lo   = (pr == '0) ? pr : pr - 1'b1;
      col_hi_s = (pc == cfg.cols_m1) ? sp : slot_inc(sp);
      col_lo_s = (pc == '0) ? sp : slot_dec(sp);

      mem.wr_en       = accept;
      mem.wr_addr     = {cur_s, cur_r};
      mem.wr_data     = req.sample;
      mem.row_addr_hi = {sp, row_hi};
      mem.row_addr_lo = {sp, row_lo};
      mem.col_addr_hi = {col_hi_s, pr};
      mem.col_addr_lo = {col_lo_s, pr};

      point.valid       = issue;
      point.row_index   = pr;
      point.col_index   = pc;
      point.row_zero    = (cfg.rows_m1 == '0);
      point.row_sh9     = (pr != '0) && (pr != cfg.rows_m1);
      point.col_zero    = (cfg.cols_m1 == '0);
      point.col_sh9     = (pc != '0) && (pc != cfg.cols_m1);
      point.last_of_run = (rem == 3'b000);
      point.frame_done  = (pr == cfg.rows_m1) && (pc == cfg.cols_m1);
   end

   // Advance the counters in column-major order
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      slot_in      = slot_ff;
      if (accept) begin
         if (!last_row) begin
            row_count_in = cur_r + 1'b1;
            col_count_in = cur_c;
            slot_in      = cur_s;
         end else if (!last_col) begin
            row_count_in = '0;
            col_count_in = cur_c + 1'b1;
            slot_in      = slot_inc(cur_s);
         end else begin
            row_count_in = '0;
            col_count_in = '0;
            slot_in      = '0;
         end
      end
   end

   // Load a new job or drop the issued point
   always_comb begin
      if (accept) begin
         pend_in = new_pend;
      end else if (issue) begin
         pend_in = rem;
      end else begin
         pend_in = pend_ff;
      end
   end

   // Count points issued but not yet delivered
   always_comb begin
      case ({issue, rsp_pop})
         2'b10:   outstanding_in = outstanding_ff + 1'b1;
         2'b01:   outstanding_in = outstanding_ff - 1'b1;
         default: outstanding_in = outstanding_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= '0;
         col_count_ff   <= '0;
         slot_ff        <= '0;
         pend_ff        <= '0;
         outstanding_ff <= '0;
      end else begin
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         slot_ff        <= slot_in;
         pend_ff        <= pend_in;
         outstanding_ff <= outstanding_in;
      end
   end

   // Hold the position of the accepted sample for its job
   always_ff @(posedge clock) begin
      if (accept) begin
         job_r_ff <= cur_r;
         job_c_ff <= cur_c;
         job_s_ff <= cur_s;
      end
   end

endmodule

// ===== src/ggcd_calc.sv =====
// Gradient arithmetic: difference, Q8.8 scaling, floor shift and saturation.
module ggcd_calc import ggcd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ggcd_point_type         point,
   input  ggcd_cfg_type           cfg,
   input  logic [SAMPLE_BITS-1:0] row_hi,
   input  logic [SAMPLE_BITS-1:0] row_lo,
   input  logic [SAMPLE_BITS-1:0] col_hi,
   input  logic [SAMPLE_BITS-1:0] col_lo,
   output ggcd_push_type          push
);

   function automatic logic signed [GRAD_W-1:0] sat_grad(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-GRAD_W:0] top;
      top = v[PROD_W-1:GRAD_W-1];
      if ((&top) || (~|top)) begin
         return v[GRAD_W-1:0];
      end else if (v[PROD_W-1]) begin
         return {1'b1, {(GRAD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(GRAD_W-1){1'b1}}};
      end
   endfunction

   logic                     s1_vld_ff, s2_vld_ff, s3_vld_ff;
   ggcd_point_type           s1_ff, s2_ff, s3_ff;
   logic signed [DIFF_W-1:0] row_diff, col_diff, row_diff_ff, col_diff_ff;
   logic signed [PROD_W-1:0] row_prod, col_prod, row_prod_ff, col_prod_ff;
   logic signed [PROD_W-1:0] row_shr, col_shr;

   // Stage 1: store data arrives; form the differences
   always_comb begin
      row_diff = $signed({row_hi[SAMPLE_BITS-1], row_hi})
               - $signed({row_lo[SAMPLE_BITS-1], row_lo});
      col_diff = $signed({col_hi[SAMPLE_BITS-1], col_hi})
               - $signed({col_lo[SAMPLE_BITS-1], col_lo});
      if (s1_ff.row_zero) begin
         row_diff = '0;
      end
      if (s1_ff.col_zero) begin
         col_diff = '0;
      end
   end

   // Stage 2: scale by the reciprocal step
   always_comb begin
      row_prod = row_diff_ff * $signed({1'b0, cfg.inv_row});
      col_prod = col_diff_ff * $signed({1'b0, cfg.inv_col});
   end

   // Stage 3: floor shift, halving again for central differences
   always_comb begin
      row_shr = s3_ff.row_sh9 ? (row_prod_ff >>> 9) : (row_prod_ff >>> 8);
      col_shr = s3_ff.col_sh9 ? (col_prod_ff >>> 9) : (col_prod_ff >>> 8);
      push.valid            = s3_vld_ff;
      push.data.row_index   = s3_ff.row_index;
      push.data.col_index   = s3_ff.col_index;
      push.data.grad_row    = sat_grad(row_shr);
      push.data.grad_col    = sat_grad(col_shr);
      push.data.last_of_run = s3_ff.last_of_run;
      push.data.frame_done  = s3_ff.frame_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= point.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   // Advance point data alongside the valid bits
   always_ff @(posedge clock) begin
      s1_ff       <= point;
      s2_ff       <= s1_ff;
      s3_ff       <= s2_ff;
      row_diff_ff <= row_diff;
      col_diff_ff <= col_diff;
      row_prod_ff <= row_prod;
      col_prod_ff <= col_prod;
   end

endmodule

// ===== src/ggcd_fifo.sv =====
// Result queue between the arithmetic pipeline and the result channel.
module ggcd_fifo import ggcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ggcd_push_type push,
   ggcd_rsp_if.source    rsp
);

   ggcd_rsp_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic               pop;
   ggcd_rsp_type       head;

   // Present the head entry
   always_comb begin
      head            = mem_ff[rd_ptr_ff];
      rsp.valid       = (count_ff != '0);
      rsp.row_index   = head.row_index;
      rsp.col_index   = head.col_index;
      rsp.grad_row    = head.grad_row;
      rsp.grad_col    = head.grad_col;
      rsp.last_of_run = head.last_of_run;
      rsp.frame_done  = head.frame_done;
      pop             = rsp.valid && rsp.ready;
   end

   always_comb begin
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Store pushed results; the issue credit keeps the queue from overflowing
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

// ===== src/grid_gradient_central_diff.sv =====
// Top level of the streaming 2-D central difference gradient block.
//
//  Channel   Dir  Handshake     Beat contents
//  req_bus   in   valid/ready   sample
//  rsp_bus   out  valid/ready   row_index, col_index, grad_row, grad_col, last_of_run,
//                               frame_done
//  csr_*     in   csr_we        csr_index, csr_wdata
//
// A sample releases at most one point, except in the last column, where it releases up to
// three points; the single read issue slot into the column store issues them one at a
// time while the result queue has credit, and the next sample is taken as the last one
// issues. Each point passes the store read, the difference and product registers and the
// saturating shift into the result queue on its way to rsp_bus.
// Reset is synchronous and clears the grid counters, the issue job and the result queue;
// the column store is not cleared. An 8-entry result queue with issue credit absorbs
// rsp_bus stalls; req_bus ready drops once the queue is committed.
module grid_gradient_central_diff import ggcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ggcd_req_if.sink             req_bus,
   ggcd_rsp_if.source           rsp_bus,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [ROW_W-1:0]      rows_m1_ff;
   logic [COL_W-1:0]      cols_m1_ff;
   logic [INV_W-1:0]      inv_row_ff, inv_col_ff;
   logic [ROWS_CFG_W-1:0] rows_raw;
   logic [ROW_W-1:0]      rows_m1_in;
   logic [COL_W-1:0]      cols_m1_in;

   ggcd_cfg_type          cfg;
   ggcd_mem_type          mem;
   ggcd_point_type        point;
   ggcd_push_type         push;
   logic                  rsp_pop;
   logic [SAMPLE_BITS-1:0] row_hi, row_lo, col_hi, col_lo;

   // Clamp written dimensions to their effective range
   always_comb begin
      rows_raw = csr_wdata[ROWS_CFG_W-1:0];
      if (rows_raw == '0) begin
         rows_m1_in = '0;
      end else if (rows_raw > ROWS_CFG_W'(MAX_ROWS)) begin
         rows_m1_in = ROW_W'(MAX_ROWS - 1);
      end else begin
         rows_m1_in = ROW_W'(rows_raw - 1'b1);
      end
      cols_m1_in = (csr_wdata[COL_W-1:0] == '0) ? '0 : csr_wdata[COL_W-1:0] - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m1_ff <= ROW_W'(MAX_ROWS - 1);
         cols_m1_ff <= '0;
         inv_row_ff <= INV_RESET;
         inv_col_ff <= INV_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS:         rows_m1_ff <= rows_m1_in;
            CSR_COLS:         cols_m1_ff <= cols_m1_in;
            CSR_INV_STEP_ROW: inv_row_ff <= csr_wdata[INV_W-1:0];
            CSR_INV_STEP_COL: inv_col_ff <= csr_wdata[INV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg     = '{rows_m1: rows_m1_ff, cols_m1: cols_m1_ff,
                      inv_row: inv_row_ff, inv_col: inv_col_ff};
   assign rsp_pop = rsp_bus.valid && rsp_bus.ready;

   ggcd_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .cfg     (cfg),
      .rsp_pop (rsp_pop),
      .mem     (mem),
      .point   (point)
   );

   // Copy for the row direction: two rows of one column
   ggcd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_row_ram (
      .clock     (clock),
      .wr_en     (mem.wr_en),
      .wr_addr   (mem.wr_addr),
      .wr_data   (mem.wr_data),
      .rd_addr_a (mem.row_addr_hi),
      .rd_addr_b (mem.row_addr_lo),
      .rd_data_a (row_hi),
      .rd_data_b (row_lo)
   );

   // Copy for the column direction: one row of two columns
   ggcd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_col_ram (
      .clock     (clock),
      .wr_en     (mem.wr_en),
      .wr_addr   (mem.wr_addr),
      .wr_data   (mem.wr_data),
      .rd_addr_a (mem.col_addr_hi),
      .rd_addr_b (mem.col_addr_lo),
      .rd_data_a (col_hi),
      .rd_data_b (col_lo)
   );

   ggcd_calc u_calc (
      .clock  (clock),
      .reset  (reset),
      .point  (point),
      .cfg    (cfg),
      .row_hi (row_hi),
      .row_lo (row_lo),
      .col_hi (col_hi),
      .col_lo (col_lo),
      .push   (push)
   );

   ggcd_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .rsp   (rsp_bus)
   );

endmodule

// ===== tb/grid_gradient_central_diff_test.sv =====
// Self-checking testbench for the streaming 2-D central difference gradient block.
`timescale 1ns / 100ps

module grid_gradient_central_diff_test;
   import ggcd_pkg::*;

   localparam int ERROR_SHOW    = 10;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 150;
   localparam int EDGE_SHIFT    = 8;
   localparam int CENTRAL_SHIFT = 9;
   localparam longint GRAD_HI   = (longint'(1) << (GRAD_W - 1)) - 1;
   localparam longint GRAD_LO   = -(longint'(1) << (GRAD_W - 1));
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   ggcd_req_if req_bus ();
   ggcd_rsp_if rsp_bus ();

   grid_gradient_central_diff DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copy and grid state of the gradient predictor
   logic [ROWS_CFG_W-1:0]         rows_reg;
   logic [COL_W-1:0]              cols_reg;
   logic [INV_W-1:0]              inv_row_reg;
   logic [INV_W-1:0]              inv_col_reg;
   logic signed [SAMPLE_BITS-1:0] grid_columns [3*MAX_ROWS];
   int unsigned                   row_pos;
   int unsigned                   col_pos;

   ggcd_rsp_type expected_points [$];
   int           error_count     = 0;
   bit           req_idle_on     = 1'b1;
   bit           rsp_idle_on     = 1'b1;
   int           rsp_hold_cycles = 0;

   always #1 clock = ~clock;

   function automatic int unsigned eff_rows(logic [ROWS_CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_ROWS) return MAX_ROWS;
      return 32'(value);
   endfunction

   function automatic int unsigned eff_cols(logic [COL_W-1:0] value);
      return (value == 0) ? 1 : 32'(value);
   endfunction

   function automatic longint sample_at(int unsigned r, int unsigned c);
      return longint'(grid_columns[(c % 3) * MAX_ROWS + r]);
   endfunction

   // Multiply by the Q8.8 reciprocal, floor shift, clamp to the gradient range
   function automatic logic signed [GRAD_W-1:0] scale_by_step(longint diff,
                                                             logic [INV_W-1:0] inv, int sh);
      longint q;
      q = (diff * longint'(inv)) >>> sh;
      if (q > GRAD_HI) q = GRAD_HI;
      if (q < GRAD_LO) q = GRAD_LO;
      return q[GRAD_W-1:0];
   endfunction

   function automatic ggcd_rsp_type gradient_point(int unsigned r, int unsigned c,
                                                   int unsigned nr, int unsigned nc);
      ggcd_rsp_type p;
      p = '0;
      p.row_index = r[ROW_W-1:0];
      p.col_index = c[COL_W-1:0];
      // forward difference on the first row, backward on the last, central inside
      if (nr > 1) begin
         if (r == 0)
            p.grad_row = scale_by_step(sample_at(1, c) - sample_at(0, c), inv_row_reg,
                                       EDGE_SHIFT);
         else if (r == nr - 1)
            p.grad_row = scale_by_step(sample_at(r, c) - sample_at(r - 1, c), inv_row_reg,
                                       EDGE_SHIFT);
         else
            p.grad_row = scale_by_step(sample_at(r + 1, c) - sample_at(r - 1, c),
                                       inv_row_reg, CENTRAL_SHIFT);
      end
      if (nc > 1) begin
         if (c == 0)
            p.grad_col = scale_by_step(sample_at(r, 1) - sample_at(r, 0), inv_col_reg,
                                       EDGE_SHIFT);
         else if (c == nc - 1)
            p.grad_col = scale_by_step(sample_at(r, c) - sample_at(r, c - 1), inv_col_reg,
                                       EDGE_SHIFT);
         else
            p.grad_col = scale_by_step(sample_at(r, c + 1) - sample_at(r, c - 1),
                                       inv_col_reg, CENTRAL_SHIFT);
      end
      p.frame_done = (r == nr - 1) && (c == nc - 1);
      return p;
   endfunction

   // Store one sample and queue the points it releases
   function automatic void predict_gradients(logic signed [SAMPLE_BITS-1:0] value);
      int unsigned  nr;
      int unsigned  nc;
      int unsigned  r;
      int unsigned  c;
      ggcd_rsp_type batch [$];
      ggcd_rsp_type tail;
      nr = eff_rows(rows_reg);
      nc = eff_cols(cols_reg);
      // a counter out of range after a register change starts a new grid
      if (row_pos >= nr || col_pos >= nc) begin
         row_pos = 0;
         col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      grid_columns[(c % 3) * MAX_ROWS + r] = value;
      if (c >= 1) batch.push_back(gradient_point(r, c - 1, nr, nc));
      if (c == nc - 1) begin
         if (r >= 1) batch.push_back(gradient_point(r - 1, c, nr, nc));
         if (r == nr - 1) batch.push_back(gradient_point(r, c, nr, nc));
      end
      if (batch.size() > 0) begin
         tail = batch.pop_back();
         tail.last_of_run = 1'b1;
         batch.push_back(tail);
      end
      foreach (batch[i]) expected_points.push_back(batch[i]);
      if (r + 1 < nr) begin
         row_pos = r + 1;
      end else begin
         row_pos = 0;
         col_pos = (c + 1 < nc) ? c + 1 : 0;
      end
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      case (idx)
         CSR_ROWS:         rows_reg    = value[ROWS_CFG_W-1:0];
         CSR_COLS:         cols_reg    = value[COL_W-1:0];
         CSR_INV_STEP_ROW: inv_row_reg = value[INV_W-1:0];
         CSR_INV_STEP_COL: inv_col_reg = value[INV_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic string point_text(ggcd_rsp_type p);
      return $sformatf("row %0d col %0d grad_row %0d grad_col %0d last %0b done %0b",
                       p.row_index, p.col_index, p.grad_row, p.grad_col, p.last_of_run,
                       p.frame_done);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_BITS'($urandom_range(0, 31) - 16);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_step();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return INV_RESET;
         default: return CSR_W'($urandom);
      endcase
   endfunction

   // Write all four registers in back-to-back beats
   task automatic set_grid(input logic [CSR_W-1:0] rows_v, input logic [CSR_W-1:0] cols_v,
                           input logic [CSR_W-1:0] inv_r, input logic [CSR_W-1:0] inv_c);
      logic [CSR_IDX_W-1:0] reg_index [4];
      logic [CSR_W-1:0]     reg_value [4];
      reg_index = '{CSR_ROWS, CSR_COLS, CSR_INV_STEP_ROW, CSR_INV_STEP_COL};
      reg_value = '{rows_v, cols_v, inv_r, inv_c};
      foreach (reg_index[i]) begin
         csr_we    <= 1'b1;
         csr_index <= reg_index[i];
         csr_wdata <= reg_value[i];
         @(posedge clock);
         apply_reg(reg_index[i], reg_value[i]);
      end
      csr_we <= 1'b0;
   endtask

   // Offer one sample beat after a random gap; valid stays high across gapless beats
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= value;
      do @(posedge clock); while (!req_bus.ready);
      predict_gradients(value);
   endtask

   // Drop valid, wait for every queued point, then let the pipeline settle
   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Reset values: 32 rows, one column, unit steps; stop part way down the column
   task automatic test_reset_defaults();
      repeat (3) send_sample(pick_sample());
      wait_drain();
   endtask

   task automatic test_single_points();
      set_grid(1, 1, INV_RESET, INV_RESET);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      wait_drain();
      // zero dimensions act as one; bits above the rows field are dropped
      set_grid(16'hFFC0, 16'h0000, '1, '1);
      send_sample(pick_sample());
      wait_drain();
   endtask

   // Full-swing checkerboard on 3x3 with the largest reciprocals
   task automatic test_edges_and_interior();
      set_grid(3, 3, '1, '1);
      for (int i = 0; i < 9; i++) send_sample((i % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN);
      wait_drain();
   endtask

   // Tiny products show the floor on negative differences
   task automatic test_step_scaling();
      set_grid(4, 1, 16'd1, 16'd0);
      send_sample(0);
      send_sample(-1);
      send_sample(1);
      send_sample(-3);
      wait_drain();
   endtask

   task automatic test_midframe_restart();
      set_grid(3, 4, INV_RESET, INV_RESET);
      repeat (5) send_sample(pick_sample());
      wait_drain();
      // shrink rows below the current row position: the grid starts over
      set_grid(2, 2, 16'd384, 16'd640);
      repeat (4) send_sample(pick_sample());
      wait_drain();
   endtask

   // Widest grid: a few columns only, then a restart through a smaller width
   task automatic test_widest_grid();
      set_grid(2, '1, pick_step(), pick_step());
      repeat (6) send_sample(pick_sample());
      wait_drain();
      set_grid(1, 1, INV_RESET, INV_RESET);
      send_sample(pick_sample());
      wait_drain();
   endtask

   // Hold the result side off while samples keep coming, so the input stalls
   task automatic test_backpressure();
      set_grid(4, 5, pick_step(), pick_step());
      req_idle_on     = 1'b0;
      rsp_hold_cycles = 150;
      repeat (20) send_sample(pick_sample());
      wait_drain();
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_grids();
      int               sent;
      int               count;
      int               frame_len;
      logic [CSR_W-1:0] rows_v;
      logic [CSR_W-1:0] cols_v;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0: rows_v = '0;
            1: rows_v = CSR_W'(MAX_ROWS);
            2: rows_v = CSR_W'($urandom_range(MAX_ROWS + 1, (1 << ROWS_CFG_W) - 1));
            default: rows_v = CSR_W'($urandom_range(1, 6));
         endcase
         cols_v = ($urandom_range(0, 7) == 0) ? '0 : CSR_W'($urandom_range(1, 5));
         if (eff_rows(rows_v[ROWS_CFG_W-1:0]) > 8 && cols_v > 2) cols_v = 2;
         // a grid left part way must restart, so no stale column is read
         if (col_pos > 0) cols_v = CSR_W'($urandom_range(1, col_pos));
         else if (row_pos > 0) rows_v = CSR_W'($urandom_range(1, row_pos));
         rows_v[CSR_W-1:ROWS_CFG_W] = (CSR_W - ROWS_CFG_W)'($urandom);
         set_grid(rows_v, cols_v, pick_step(), pick_step());
         frame_len = eff_rows(rows_v[ROWS_CFG_W-1:0]) * eff_cols(cols_v);
         count = (frame_len > 1 && $urandom_range(0, 3) == 0) ?
                 $urandom_range(1, frame_len - 1) : frame_len;
         repeat (count) send_sample(pick_sample());
         sent += count;
         wait_drain();
      end
   endtask

   // Result side: random stalls per beat, or one long hold when asked
   initial begin : rsp_side
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall           = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = rsp_idle_on ? $urandom_range(0, 12) : 0;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Compare each result beat with the oldest predicted point
   always @(posedge clock) begin : check_beat
      ggcd_rsp_type got;
      ggcd_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.row_index   = rsp_bus.row_index;
         got.col_index   = rsp_bus.col_index;
         got.grad_row    = rsp_bus.grad_row;
         got.grad_col    = rsp_bus.grad_col;
         got.last_of_run = rsp_bus.last_of_run;
         got.frame_done  = rsp_bus.frame_done;
         if (expected_points.size() == 0) begin
            error_count++;
            if (error_count <= ERROR_SHOW)
               $display("ERROR: result beat with none pending: %s", point_text(got));
         end else begin
            want = expected_points.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= ERROR_SHOW) begin
                  $display("ERROR: result mismatch at %0t", $realtime);
                  $display("   expected %s", point_text(want));
                  $display("   actual   %s", point_text(got));
               end
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      csr_we         <= 1'b0;
      csr_index      <= CSR_ROWS;
      csr_wdata      <= '0;
      req_bus.valid  <= 1'b0;
      req_bus.sample <= '0;
      rows_reg    = ROWS_CFG_W'(MAX_ROWS);
      cols_reg    = 1;
      inv_row_reg = INV_RESET;
      inv_col_reg = INV_RESET;
      row_pos     = 0;
      col_pos     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_single_points();
      test_edges_and_interior();
      test_step_scaling();
      test_midframe_restart();
      test_widest_grid();
      test_backpressure();
      test_random_grids();

      if (error_count == 0 && expected_points.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
